[hw/rtl/accel_tilt_roll_pitch_defines.svh]
// ----------------------------------------------------------------------------
// accel_tilt_roll_pitch_defines
// assertion macros shared by the tilt block
// ----------------------------------------------------------------------------
`ifndef ACCEL_TILT_ROLL_PITCH_DEFINES_SVH
`define ACCEL_TILT_ROLL_PITCH_DEFINES_SVH

// implication checked on every edge out of reset
`define ATRP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define ATRP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/atrp_pkg.sv]
// ----------------------------------------------------------------------------
// atrp_pkg
// shared types and constants of the tilt angle pipeline
// ----------------------------------------------------------------------------
package atrp_pkg;

	localparam int Steps = 24;
	localparam int VecW = 48;
	localparam int AccW = 25;
	localparam int RootSteps = 31;
	localparam int RadW = 62;
	localparam int RootW = 31;

	typedef logic signed [VecW-1:0] vec_t;
	typedef logic signed [AccW-1:0] acc_t;

	// per-item side info carried with the cordic data
	typedef struct packed {
		logic valid;
		logic zero_num;
		logic zero_den;
		logic neg_a;
		logic neg_b;
		logic is_roll_pos;
	} tag_t;

	// cordic vector of one angle
	typedef struct packed {
		vec_t x;
		vec_t y;
		acc_t acc;
		tag_t tag;
	} cvec_t;

	// square root cell payload
	typedef struct packed {
		logic [RadW-1:0] rem;
		logic [RootW-1:0] root;
		logic [RadW-1:0] rad;
		logic [15:0] mx;
		logic [15:0] my;
		logic [15:0] mz;
		logic sx;
		logic sy;
		logic sz;
		logic valid;
	} sq_t;

	function automatic acc_t step_angle(input int i);
		acc_t a;
		case (i)
			0: a = 25'd4608000;
			1: a = 25'd2720261;
			2: a = 25'd1437311;
			3: a = 25'd729602;
			4: a = 25'd366217;
			5: a = 25'd183287;
			6: a = 25'd91666;
			7: a = 25'd45836;
			8: a = 25'd22918;
			9: a = 25'd11459;
			10: a = 25'd5730;
			11: a = 25'd2865;
			12: a = 25'd1432;
			13: a = 25'd716;
			14: a = 25'd358;
			15: a = 25'd179;
			16: a = 25'd90;
			17: a = 25'd45;
			18: a = 25'd22;
			19: a = 25'd11;
			20: a = 25'd6;
			21: a = 25'd3;
			default: a = 25'd1;
		endcase
		return a;
	endfunction

	// magnitude shift toward zero
	function automatic vec_t shr_mag(input vec_t v, input int k);
		vec_t m;
		m = v[VecW-1] ? -v : v;
		m = m >>> k;
		return v[VecW-1] ? -m : m;
	endfunction

endpackage

[hw/rtl/accel_tilt_roll_pitch.sv]
// ----------------------------------------------------------------------------
// accel_tilt_roll_pitch
// roll and pitch from one three-axis sample via sqrt and cordic cell chains
// ----------------------------------------------------------------------------
// channel   dir  handshake      payload
// sample    in   start / busy   accel_x, accel_y, accel_z
// angles    out  done strobe    roll_centideg, pitch_centideg
//
// one sample per cycle; busy is always low
// pipeline: entry register, 31 sqrt cells, 24 cordic cells and output register
// the sqrt chain sets the latency, the roll path is delayed to match
// reset clears the cell chains and the done strobe; the receiver cannot stall
`include "accel_tilt_roll_pitch_defines.svh"

module accel_tilt_roll_pitch (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	output logic               done,
	output logic signed [15:0] roll_centideg,
	output logic signed [14:0] pitch_centideg
);

	localparam int RS = atrp_pkg::RootSteps;
	localparam int CS = atrp_pkg::Steps;

	atrp_pkg::sq_t sq [RS+1];
	atrp_pkg::cvec_t rc [CS+1];
	atrp_pkg::cvec_t pc [CS+1];
	atrp_pkg::cvec_t rdl [RS];

	logic [16:0] ax_w, ay_w, az_w;
	logic [31:0] sumsq;
	atrp_pkg::cvec_t r0, p0;
	logic signed [atrp_pkg::AccW-1:0] rclamp, pclamp;
	logic [14:0] rang, pang;
	logic signed [15:0] roll_w;
	logic signed [14:0] pitch_w;
	logic done_q;
	logic signed [15:0] roll_q;
	logic signed [14:0] pitch_q;

	assign busy = 1'b0;

	always_comb begin
		ax_w = accel_x[15] ? 17'(-{accel_x[15], accel_x}) : 17'({1'b0, accel_x});
		ay_w = accel_y[15] ? 17'(-{accel_y[15], accel_y}) : 17'({1'b0, accel_y});
		az_w = accel_z[15] ? 17'(-{accel_z[15], accel_z}) : 17'({1'b0, accel_z});
	end

	// radicand (y^2+z^2)*2^30 padded to 62 bits: sqrt has 31 bits
	always_comb begin
		sumsq = 32'(ay_w * ay_w) + 32'(az_w * az_w);
	end

	// entry register of the sqrt chain; a 17x17 square each
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq[0] <= '0;
		end else begin
			sq[0].valid <= start;
			sq[0].rem <= '0;
			sq[0].root <= '0;
			sq[0].rad <= {sumsq, 30'd0};
			sq[0].mx <= ax_w[15:0] | {ax_w[16], 15'd0};
			sq[0].my <= ay_w[15:0] | {ay_w[16], 15'd0};
			sq[0].mz <= az_w[15:0] | {az_w[16], 15'd0};
			sq[0].sx <= accel_x[15];
			sq[0].sy <= accel_y[15];
			sq[0].sz <= accel_z[15];
		end
	end

	for (genvar g = 0; g < RS; g++) begin : g_sq
		atrp_sqrt_cell u_cell (
			.clk(clk), .arst_n(arst_n), .din(sq[g]), .dout(sq[g+1])
		);
	end

	// roll cordic input formed at entry, delayed alongside the sqrt chain
	always_comb begin
		r0 = '0;
		r0.x = atrp_pkg::VecW'({sq[0].mz, 29'd0});
		r0.y = atrp_pkg::VecW'({sq[0].my, 29'd0});
		r0.tag.valid = sq[0].valid;
		r0.tag.zero_num = (sq[0].my == 16'd0);
		r0.tag.zero_den = (sq[0].mz == 16'd0);
		r0.tag.neg_a = sq[0].sy;
		r0.tag.neg_b = sq[0].sz;
		r0.tag.is_roll_pos = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RS; i++) rdl[i] <= '0;
		end else begin
			rdl[0] <= r0;
			for (int i = 1; i < RS; i++) rdl[i] <= rdl[i-1];
		end
	end

	assign rc[0] = rdl[RS-1];

	// pitch cordic input from the sqrt chain output
	always_comb begin
		p0 = '0;
		p0.x = atrp_pkg::VecW'({sq[RS].root, 14'd0});
		p0.y = atrp_pkg::VecW'({sq[RS].mx, 29'd0});
		p0.tag.valid = sq[RS].valid;
		p0.tag.zero_num = (sq[RS].mx == 16'd0);
		p0.tag.zero_den = (sq[RS].root == '0);
		p0.tag.neg_a = sq[RS].sx;
		p0.tag.neg_b = 1'b0;
		p0.tag.is_roll_pos = (sq[RS].mx != 16'd0) && !sq[RS].sx;
	end

	assign pc[0] = p0;

	for (genvar g = 0; g < CS; g++) begin : g_cor
		atrp_cordic_cell u_roll (
			.clk(clk), .arst_n(arst_n), .idx(5'(g)), .din(rc[g]), .dout(rc[g+1])
		);
		atrp_cordic_cell u_pitch (
			.clk(clk), .arst_n(arst_n), .idx(5'(g)), .din(pc[g]), .dout(pc[g+1])
		);
	end

	always_comb begin
		rclamp = rc[CS].acc;
		if (rclamp < 0) rclamp = '0;
		if (rclamp > 25'sd9216000) rclamp = 25'sd9216000;
		pclamp = pc[CS].acc;
		if (pclamp < 0) pclamp = '0;
		if (pclamp > 25'sd9216000) pclamp = 25'sd9216000;
		rang = 15'((rclamp + 25'sd512) >>> 10);
		pang = 15'((pclamp + 25'sd512) >>> 10);
		if (rc[CS].tag.zero_num) rang = 15'd0;
		else if (rc[CS].tag.zero_den) rang = 15'd9000;
		if (pc[CS].tag.zero_num) pang = 15'd0;
		else if (pc[CS].tag.zero_den) pang = 15'd9000;
		roll_w = 16'(rang);
		if (rc[CS].tag.neg_b) roll_w = 16'sd18000 - roll_w;
		if (rc[CS].tag.neg_a) roll_w = -roll_w;
		pitch_w = pang;
		if (pc[CS].tag.is_roll_pos) pitch_w = -pitch_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= pc[CS].tag.valid;
		end
	end

	always_ff @(posedge clk) begin
		roll_q <= roll_w;
		pitch_q <= pitch_w;
	end

	assign done = done_q;
	assign roll_centideg = roll_q;
	assign pitch_centideg = pitch_q;

	`ATRP_ASSERT_IMP(a_paths_aligned, pc[CS].tag.valid != rc[CS].tag.valid, 1'b0, "roll and pitch paths out of step")
	`ATRP_ASSERT_NXT(a_roll_range, pc[CS].tag.valid, roll_q <= 16'sd18000 && roll_q >= -16'sd18000, "roll out of range")
	`ATRP_ASSERT_NXT(a_pitch_range, pc[CS].tag.valid, pitch_q <= 15'sd9000 && pitch_q >= -15'sd9000, "pitch out of range")

endmodule

[hw/rtl/atrp_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// atrp_sqrt_cell
// one restoring step of the digit-by-digit square root
// ----------------------------------------------------------------------------
module atrp_sqrt_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  atrp_pkg::sq_t  din,
	output atrp_pkg::sq_t  dout
);

	logic [atrp_pkg::RadW+1:0] rem_w;
	logic [atrp_pkg::RadW+1:0] trial;
	atrp_pkg::sq_t nxt;

	always_comb begin
		nxt = din;
		rem_w = {din.rem, din.rad[atrp_pkg::RadW-1 -: 2]};
		trial = (atrp_pkg::RadW+2)'({din.root, 2'b01});
		nxt.rad = {din.rad[atrp_pkg::RadW-3:0], 2'b00};
		if (rem_w >= trial) begin
			nxt.rem = atrp_pkg::RadW'(rem_w - trial);
			nxt.root = {din.root[atrp_pkg::RootW-2:0], 1'b1};
		end else begin
			nxt.rem = atrp_pkg::RadW'(rem_w);
			nxt.root = {din.root[atrp_pkg::RootW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else begin
			dout <= nxt;
		end
	end

endmodule

[hw/rtl/atrp_cordic_cell.sv]
// ----------------------------------------------------------------------------
// atrp_cordic_cell
// one vectoring rotation with a fixed shift and angle step
// ----------------------------------------------------------------------------
module atrp_cordic_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [4:0]       idx,
	input  atrp_pkg::cvec_t  din,
	output atrp_pkg::cvec_t  dout
);

	atrp_pkg::vec_t dx;
	atrp_pkg::vec_t dy;
	atrp_pkg::acc_t da;
	atrp_pkg::cvec_t nxt;

	always_comb begin
		dx = atrp_pkg::shr_mag(din.y, int'(idx));
		dy = atrp_pkg::shr_mag(din.x, int'(idx));
		da = atrp_pkg::step_angle(int'(idx));
		nxt = din;
		if (din.y > 0) begin
			nxt.x = din.x + dx;
			nxt.y = din.y - dy;
			nxt.acc = din.acc + da;
		end else begin
			nxt.x = din.x - dx;
			nxt.y = din.y + dy;
			nxt.acc = din.acc - da;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else begin
			dout <= nxt;
		end
	end

endmodule
